// ----- src/two_point_calibrate_and_frame_pack_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the two-point calibration frame packer
// Shared property forms used by the port-level checker.
// ----------------------------------------------------------------------------
`ifndef TWO_POINT_CALIBRATE_AND_FRAME_PACK_DEFINES_SVH
`define TWO_POINT_CALIBRATE_AND_FRAME_PACK_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TPCFP_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("port check failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define TPCFP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("port check failed: next-cycle implication");

`endif

// ----- src/tpcfp_pkg.sv -----
// ----------------------------------------------------------------------------
// tpcfp_pkg
// Types and constants shared by the calibration lanes, packer and top level.
// ----------------------------------------------------------------------------
package tpcfp_pkg;

   localparam int RAW_W      = 10;
   localparam int CAL_W      = 20;
   localparam int CSR_IDX_W  = 3;
   localparam int PAIR_W     = 2;
   localparam int PAIR_COUNT = 4;
   localparam int VALUE_W    = 10;
   localparam int DEN_W      = 14;
   localparam int REM_W      = 24;
   localparam int DIV_STEPS  = 10;
   // Lane depth: operand stage, numerator stage, one stage per quotient bit.
   localparam int LANE_DEPTH = DIV_STEPS + 2;

   localparam logic [CAL_W-1:0]   CAL_RESET = 20'd944230;
   localparam logic [VALUE_W-1:0] VALUE_MAX = 10'd1023;
   localparam logic [PAIR_W-1:0]  SYNC_PAIR = 2'd0;

   typedef struct packed {
      logic [PAIR_W-1:0] pair_index;
      logic [RAW_W-1:0]  raw_first;
      logic [RAW_W-1:0]  raw_second;
      logic              event_active;
   } req_type;

   typedef struct packed {
      logic [7:0] frame_byte_zero;
      logic [6:0] frame_byte_one;
      logic [6:0] frame_byte_two;
   } rsp_type;

   typedef struct packed {
      logic             present;
      logic [RAW_W-1:0] lo;
      logic [RAW_W-1:0] hi;
      logic [RAW_W-1:0] raw;
   } lane_in_type;

   typedef struct packed {
      logic               valid;
      logic [PAIR_W-1:0]  pair_index;
      logic               event_active;
      logic [VALUE_W-1:0] value_first;
      logic [VALUE_W-1:0] value_second;
   } pack_in_type;

endpackage

// ----- src/tpcfp_lane.sv -----
// ----------------------------------------------------------------------------
// tpcfp_lane
// One calibration lane: two-point map of a raw count through a pipelined
// restoring divider, one quotient bit per stage, clamped to 0..1023.
// ----------------------------------------------------------------------------
module tpcfp_lane
   import tpcfp_pkg::*;
(
   input  logic               clock,
   input  logic               advance,
   input  lane_in_type        lane_in,
   output logic [VALUE_W-1:0] value
);

   // Operand stage.
   logic                      s1_present_ff;
   logic                      s1_dz_ff;
   logic                      s1_gt_ff;
   logic [RAW_W-1:0]          s1_ad_ff;
   logic signed [RAW_W:0]     s1_ts_ff;

   logic signed [RAW_W:0]     d_in;
   logic signed [RAW_W:0]     t_in;
   logic signed [RAW_W:0]     d_abs_in;
   logic signed [RAW_W:0]     ts_in;

   always_comb begin
      d_in     = $signed({1'b0, lane_in.hi}) - $signed({1'b0, lane_in.lo});
      t_in     = $signed({1'b0, lane_in.raw}) - $signed({1'b0, lane_in.lo});
      d_abs_in = d_in[RAW_W] ? -d_in : d_in;
      ts_in    = d_in[RAW_W] ? -t_in : t_in;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_present_ff <= lane_in.present;
         s1_dz_ff      <= (d_in == '0);
         s1_gt_ff      <= (lane_in.raw > lane_in.lo);
         s1_ad_ff      <= d_abs_in[RAW_W-1:0];
         s1_ts_ff      <= ts_in;
      end
   end

   // Numerator, denominator and the clamp decision.
   logic [REM_W:0]   num_in;
   logic [DEN_W-1:0] den_in;
   logic             num_neg_in;
   logic             num_big_in;
   logic             fixed_in;
   logic             fmax_in;

   always_comb begin
      num_in     = {5'b0, s1_ad_ff, 10'b0} + {s1_ts_ff[RAW_W], s1_ts_ff, 13'b0};
      den_in     = {1'b0, s1_ad_ff, 3'b0} + {3'b0, s1_ad_ff, 1'b0};
      num_neg_in = num_in[REM_W];
      num_big_in = !num_neg_in && (num_in[REM_W-1:0] >= {den_in, 10'b0});
      fixed_in   = !s1_present_ff || s1_dz_ff || num_neg_in || num_big_in;
      fmax_in    = s1_present_ff && (s1_dz_ff ? s1_gt_ff : num_big_in);
   end

   // Divider stages; entry 0 is the numerator stage.
   logic [REM_W-1:0]   rem_ff   [0:DIV_STEPS];
   logic [DEN_W-1:0]   den_ff   [0:DIV_STEPS];
   logic [VALUE_W-1:0] quo_ff   [0:DIV_STEPS];
   logic               fixed_ff [0:DIV_STEPS];
   logic               fmax_ff  [0:DIV_STEPS];

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0]   <= num_in[REM_W-1:0];
         den_ff[0]   <= den_in;
         quo_ff[0]   <= '0;
         fixed_ff[0] <= fixed_in;
         fmax_ff[0]  <= fmax_in;
      end
   end

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      localparam int BIT = DIV_STEPS - 1 - k;

      logic [REM_W-1:0]   sub_in;
      logic               take_in;
      logic [VALUE_W-1:0] quo_in;

      always_comb begin
         sub_in  = {{(REM_W-DEN_W){1'b0}}, den_ff[k]} << BIT;
         take_in = (rem_ff[k] >= sub_in);
         quo_in  = quo_ff[k];
         quo_in[BIT] = take_in;
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k+1]   <= take_in ? (rem_ff[k] - sub_in) : rem_ff[k];
            den_ff[k+1]   <= den_ff[k];
            quo_ff[k+1]   <= quo_in;
            fixed_ff[k+1] <= fixed_ff[k];
            fmax_ff[k+1]  <= fmax_ff[k];
         end
      end
   end

   assign value = fixed_ff[DIV_STEPS]
                ? (fmax_ff[DIV_STEPS] ? VALUE_MAX : '0)
                : quo_ff[DIV_STEPS];

endmodule

// ----- src/tpcfp_pack.sv -----
// ----------------------------------------------------------------------------
// tpcfp_pack
// Merges the two lane values into the three-byte frame and holds the result
// register of the response channel.
// ----------------------------------------------------------------------------
module tpcfp_pack
   import tpcfp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        advance,
   input  pack_in_type pack_in,
   output logic        rsp_valid,
   output rsp_type     rsp_data
);

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   rsp_type rsp_data_in;

   always_comb begin
      rsp_data_in.frame_byte_zero = {(pack_in.pair_index == SYNC_PAIR),
                                     pack_in.value_first[6:0]};
      rsp_data_in.frame_byte_one  = pack_in.value_second[6:0];
      // The event bit only rides along with pairs zero and one.
      rsp_data_in.frame_byte_two  = {pack_in.value_first[9:7],
                                     pack_in.value_second[9:7],
                                     !pack_in.pair_index[1] && pack_in.event_active};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= pack_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- src/two_point_calibrate_and_frame_pack.sv -----
// ----------------------------------------------------------------------------
// two_point_calibrate_and_frame_pack
// Two-point calibration of a channel pair and packing into a 3-byte frame.
// ----------------------------------------------------------------------------
// Each request carries a pair index and two raw 10-bit counts; both counts are
// calibrated in parallel lanes as floor((1024*d + 8192*(x-lo)) / (10*d)) with
// d = hi - lo, exact and clamped to 0..1023, and merged into one response of
// an 8-bit and two 7-bit bytes (sync bit on byte zero for pair zero, event on
// byte two for pairs zero and one). The block accepts one request every clock
// cycle unless rsp_stall holds a response; a response passes through the
// operand and numerator registers, the ten-stage restoring divider in each
// lane and the output register. While a response waits on rsp_stall the whole
// pipeline holds, so req_stall is high exactly when rsp_valid and rsp_stall are
// both high. The user must write calibration registers through the csr port
// only while the block is idle (not enforced). They reset to lo 102, hi 922.
// Channels at or above CHANNEL_COUNT calibrate to zero and ignore writes.
// ----------------------------------------------------------------------------
module two_point_calibrate_and_frame_pack
   import tpcfp_pkg::*;
#(
   parameter int CHANNEL_COUNT = 8
)(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CAL_W-1:0]     csr_data
);

   localparam logic [CSR_IDX_W:0] CH_LIMIT = (CSR_IDX_W+1)'(CHANNEL_COUNT);

   // The pipeline moves as a whole unless a finished response is held back.
   logic advance;
   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;

   // Calibration registers, split by even and odd channel so that each lane
   // reads its own bank.
   logic [CAL_W-1:0] cal_even_ff [0:PAIR_COUNT-1];
   logic [CAL_W-1:0] cal_odd_ff  [0:PAIR_COUNT-1];
   logic             csr_hit;

   assign csr_hit = csr_write && ({1'b0, csr_index} < CH_LIMIT);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < PAIR_COUNT; p++) begin
            cal_even_ff[p] <= CAL_RESET;
            cal_odd_ff[p]  <= CAL_RESET;
         end
      end else if (csr_hit) begin
         if (csr_index[0]) begin
            cal_odd_ff[csr_index[CSR_IDX_W-1:1]]  <= csr_data;
         end else begin
            cal_even_ff[csr_index[CSR_IDX_W-1:1]] <= csr_data;
         end
      end
   end

   // Lane operands for the request at the input.
   lane_in_type lane_first_in;
   lane_in_type lane_second_in;
   logic [CAL_W-1:0] cal_first;
   logic [CAL_W-1:0] cal_second;

   always_comb begin
      cal_first  = cal_even_ff[req_data.pair_index];
      cal_second = cal_odd_ff[req_data.pair_index];

      lane_first_in.present  = ({1'b0, req_data.pair_index, 1'b0} < CH_LIMIT);
      lane_first_in.lo       = cal_first[RAW_W-1:0];
      lane_first_in.hi       = cal_first[CAL_W-1:RAW_W];
      lane_first_in.raw      = req_data.raw_first;

      lane_second_in.present = ({1'b0, req_data.pair_index, 1'b1} < CH_LIMIT);
      lane_second_in.lo      = cal_second[RAW_W-1:0];
      lane_second_in.hi      = cal_second[CAL_W-1:RAW_W];
      lane_second_in.raw     = req_data.raw_second;
   end

   logic [VALUE_W-1:0] value_first;
   logic [VALUE_W-1:0] value_second;

   tpcfp_lane u_lane_first (
      .clock   (clock),
      .advance (advance),
      .lane_in (lane_first_in),
      .value   (value_first)
   );

   tpcfp_lane u_lane_second (
      .clock   (clock),
      .advance (advance),
      .lane_in (lane_second_in),
      .value   (value_second)
   );

   // Valid bits and the frame sideband travel alongside the lanes.
   logic              vld_ff   [0:LANE_DEPTH-1];
   logic [PAIR_W-1:0] pair_ff  [0:LANE_DEPTH-1];
   logic              event_ff [0:LANE_DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < LANE_DEPTH; s++) begin
            vld_ff[s] <= 1'b0;
         end
      end else if (advance) begin
         vld_ff[0] <= req_valid;
         for (int s = 1; s < LANE_DEPTH; s++) begin
            vld_ff[s] <= vld_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pair_ff[0]  <= req_data.pair_index;
         event_ff[0] <= req_data.event_active;
         for (int s = 1; s < LANE_DEPTH; s++) begin
            pair_ff[s]  <= pair_ff[s-1];
            event_ff[s] <= event_ff[s-1];
         end
      end
   end

   pack_in_type pack_in;

   always_comb begin
      pack_in.valid        = vld_ff[LANE_DEPTH-1];
      pack_in.pair_index   = pair_ff[LANE_DEPTH-1];
      pack_in.event_active = event_ff[LANE_DEPTH-1];
      pack_in.value_first  = value_first;
      pack_in.value_second = value_second;
   end

   tpcfp_pack u_pack (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .pack_in   (pack_in),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- src/tpcfp_checker.sv -----
// ----------------------------------------------------------------------------
// tpcfp_checker
// Port-level checks on the calibration frame packer, bound to the top level.
// ----------------------------------------------------------------------------
`include "two_point_calibrate_and_frame_pack_defines.svh"

module tpcfp_checker
   import tpcfp_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input rsp_type              rsp_data
);

   // A held response stays offered.
   `TPCFP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   // A held response keeps its frame.
   `TPCFP_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_data))

   // The input is only held back by a waiting response.
   `TPCFP_ASSERT_SAME(a_req_stall_cause, clock, reset, req_stall, rsp_valid && rsp_stall)

   // Nothing is offered in the first cycle after reset.
   `TPCFP_ASSERT_SAME(a_empty_after_reset, clock, reset, $past(reset), !rsp_valid)

endmodule

bind two_point_calibrate_and_frame_pack tpcfp_checker u_tpcfp_checker (.*);

// ----- verif/two_point_calibrate_and_frame_pack_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_point_calibrate_and_frame_pack_test
// Self-checking bench for the two-point calibration frame packer. Requests
// flow through a valid/stall channel with random gaps on both sides, and a
// frame ledger predicts every packed frame from its own copy of the eight
// calibration registers. Frames are compared in order, field by field.
// ----------------------------------------------------------------------------
module two_point_calibrate_and_frame_pack_test
   import tpcfp_pkg::*;
();

   localparam int CHANNEL_COUNT = 8;
   // Used to size the wait for stray frames at the end of the run.
   localparam int LATENCY       = 13;
   // The slowest legal run is about 1600 requests plus the drains between
   // phases, so this leaves a wide margin.
   localparam int CYCLE_LIMIT   = 400000;
   localparam int PHASE_COUNT   = 6;
   localparam int PHASE_ITEMS   = 260;
   localparam int PRINT_CAP     = 40;

   // -------------------------------------------------------------------------
   // Frame ledger: holds the calibration points and the queue of frames that
   // the block still owes, and checks each frame that comes out.
   // -------------------------------------------------------------------------
   class frame_ledger;
      logic [CAL_W-1:0] cal_points [CHANNEL_COUNT];
      rsp_type          frames_due [$];
      int unsigned      mismatches;

      function new();
         foreach (cal_points[i]) cal_points[i] = CAL_RESET;
         mismatches = 0;
      endfunction

      // Channels that do not exist ignore their register writes.
      function void set_calibration(int channel, logic [CAL_W-1:0] value);
         if (channel < CHANNEL_COUNT) cal_points[channel] = value;
      endfunction

      function logic [RAW_W-1:0] low_point(int channel);
         return cal_points[channel][RAW_W-1:0];
      endfunction

      function logic [RAW_W-1:0] high_point(int channel);
         return cal_points[channel][2*RAW_W-1:RAW_W];
      endfunction

      // Exact form of 102.4 + 819.2 * (x - lo) / (hi - lo), floored and
      // clamped to the 10-bit range.
      function logic [VALUE_W-1:0] calibrate_count(int channel, logic [RAW_W-1:0] raw);
         longint lo, hi, span, num, den, quot;
         if (channel >= CHANNEL_COUNT) return '0;
         lo   = low_point(channel);
         hi   = high_point(channel);
         span = hi - lo;
         // Coincident points give a hard step at the low point.
         if (span == 0) return (longint'(raw) <= lo) ? '0 : VALUE_MAX;
         num = 1024 * span + 8192 * (longint'(raw) - lo);
         den = 10 * span;
         // Reversed points: move the sign onto the numerator first.
         if (den < 0) begin
            num = -num;
            den = -den;
         end
         if (num >= 0) quot = num / den;
         else quot = -((-num + den - 1) / den);
         if (quot < 0) return '0;
         if (quot > longint'(VALUE_MAX)) return VALUE_MAX;
         return quot[VALUE_W-1:0];
      endfunction

      function void note_request(req_type item);
         logic [VALUE_W-1:0] first_value, second_value;
         rsp_type            frame;
         first_value  = calibrate_count(2 * item.pair_index, item.raw_first);
         second_value = calibrate_count(2 * item.pair_index + 1, item.raw_second);
         frame.frame_byte_zero = {item.pair_index == SYNC_PAIR, first_value[6:0]};
         frame.frame_byte_one  = second_value[6:0];
         frame.frame_byte_two  = {first_value[9:7], second_value[9:7],
                                  item.event_active & (item.pair_index <= 2'd1)};
         frames_due.push_back(frame);
      endfunction

      task report_mismatch(string what);
         if (mismatches < PRINT_CAP) $display("mismatch at %0t: %s", $time, what);
         mismatches++;
      endtask

      task check_frame(rsp_type got);
         rsp_type want;
         if (frames_due.size() == 0) begin
            report_mismatch($sformatf("unexpected frame %h", got));
            return;
         end
         want = frames_due.pop_front();
         if (got.frame_byte_zero !== want.frame_byte_zero)
            report_mismatch($sformatf("frame_byte_zero got %h want %h",
                                      got.frame_byte_zero, want.frame_byte_zero));
         if (got.frame_byte_one !== want.frame_byte_one)
            report_mismatch($sformatf("frame_byte_one got %h want %h",
                                      got.frame_byte_one, want.frame_byte_one));
         if (got.frame_byte_two !== want.frame_byte_two)
            report_mismatch($sformatf("frame_byte_two got %h want %h",
                                      got.frame_byte_two, want.frame_byte_two));
      endtask

      function int outstanding();
         return frames_due.size();
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_stall;
   rsp_type              rsp_data;
   logic                 csr_write;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CAL_W-1:0]     csr_data;

   frame_ledger book = new();
   // When set, the sender or the receiver runs without any idle cycles.
   bit          send_quiet;
   bit          recv_quiet;
   int unsigned cycles;

   two_point_calibrate_and_frame_pack #(
      .CHANNEL_COUNT(CHANNEL_COUNT)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Every frame accepted at a rising edge is checked against the oldest
   // prediction. Values read here are the ones present before the edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) book.check_frame(rsp_data);
   end

   // Receiver: before each frame it holds stall high for a random number of
   // cycles, then drops it and waits for a frame to be taken. The stall may
   // fall on an idle output, a waiting frame, or the middle of a burst.
   initial begin
      int unsigned hold;
      rsp_stall = 1'b0;
      @(negedge clock);
      forever begin
         hold = recv_quiet ? 0 : $urandom_range(0, 15);
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         @(negedge clock);
      end
   end

   function automatic req_type make_request(logic [PAIR_W-1:0] pair, logic [RAW_W-1:0] first,
                                            logic [RAW_W-1:0] second, logic event_bit);
      req_type item;
      item.pair_index   = pair;
      item.raw_first    = first;
      item.raw_second   = second;
      item.event_active = event_bit;
      return item;
   endfunction

   // Sends one request after a random gap. The request is noted in the
   // ledger at the edge that accepts it. Valid stays high on return so that
   // a following request with no gap goes out back to back.
   task automatic push_request(req_type item);
      int unsigned gap;
      gap = send_quiet ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      book.note_request(item);
      @(negedge clock);
   endtask

   // Stops sending and waits until every predicted frame has come back.
   // At least one falling edge passes, so valid is never lowered and raised
   // again within one time step.
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (book.outstanding() != 0);
   endtask

   // One register write per cycle; the caller drops csr_write after the
   // last one. The block must be idle, which the callers make sure of.
   task automatic write_calibration(int channel, logic [RAW_W-1:0] lo, logic [RAW_W-1:0] hi);
      csr_write <= 1'b1;
      csr_index <= channel[CSR_IDX_W-1:0];
      csr_data  <= {hi, lo};
      book.set_calibration(channel, {hi, lo});
      @(negedge clock);
   endtask

   // Random calibration points: mostly a normal rising line, with equal,
   // reversed, end-of-range and fully random register values mixed in.
   task automatic randomize_channel(int channel);
      logic [RAW_W-1:0] lo, hi;
      case ($urandom_range(0, 9))
         0: begin
            lo = RAW_W'($urandom_range(0, 1023));
            hi = lo;
         end
         1: begin
            lo = RAW_W'($urandom_range(1, 1023));
            hi = RAW_W'($urandom_range(0, lo - 1));
         end
         2: begin
            lo = RAW_W'($urandom_range(0, 1023));
            hi = RAW_W'($urandom_range(0, 1023));
         end
         3: begin
            lo = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
            hi = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
         end
         default: begin
            lo = RAW_W'($urandom_range(0, 400));
            hi = RAW_W'($urandom_range(600, 1023));
         end
      endcase
      write_calibration(channel, lo, hi);
   endtask

   // Raw counts cluster around the channel's own calibration points, where
   // the floor and the clamps change, and otherwise spread over the range.
   function automatic logic [RAW_W-1:0] pick_raw(int channel);
      int value;
      case ($urandom_range(0, 5))
         0: value = int'(book.low_point(channel)) + int'($urandom_range(0, 6)) - 3;
         1: value = int'(book.high_point(channel)) + int'($urandom_range(0, 6)) - 3;
         default: value = int'($urandom_range(0, 1023));
      endcase
      if (value < 0) value = 0;
      if (value > 1023) value = 1023;
      return value[RAW_W-1:0];
   endfunction

   initial begin
      logic [PAIR_W-1:0] pair;
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      csr_write  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      send_quiet = 1'b0;
      recv_quiet = 1'b0;
      cycles     = 0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset calibration (lo 102, hi 922): raw extremes, the points
      // themselves and their neighbors, every pair with the event both ways.
      push_request(make_request(2'd0, 10'd0, 10'd1023, 1'b1));
      push_request(make_request(2'd0, 10'd102, 10'd922, 1'b0));
      push_request(make_request(2'd1, 10'd101, 10'd923, 1'b1));
      push_request(make_request(2'd1, 10'd103, 10'd921, 1'b0));
      push_request(make_request(2'd2, 10'd1023, 10'd0, 1'b1));
      push_request(make_request(2'd2, 10'd512, 10'd511, 1'b0));
      push_request(make_request(2'd3, 10'd0, 10'd0, 1'b1));
      push_request(make_request(2'd3, 10'd1023, 10'd1023, 1'b0));
      wait_drained();

      // Special points: equal points in the middle, reversed lines, the full
      // range both ways, equal points at both ends (register all zeros and
      // all ones) and a very steep line.
      write_calibration(0, 10'd500, 10'd500);
      write_calibration(1, 10'd900, 10'd100);
      write_calibration(2, 10'd0, 10'd1023);
      write_calibration(3, 10'd1023, 10'd0);
      write_calibration(4, 10'd0, 10'd0);
      write_calibration(5, 10'd1023, 10'd1023);
      write_calibration(6, 10'd1, 10'd2);
      write_calibration(7, 10'd700, 10'd300);
      csr_write <= 1'b0;
      push_request(make_request(2'd0, 10'd500, 10'd100, 1'b1));
      push_request(make_request(2'd0, 10'd501, 10'd900, 1'b0));
      push_request(make_request(2'd0, 10'd499, 10'd1023, 1'b1));
      push_request(make_request(2'd1, 10'd0, 10'd1023, 1'b1));
      push_request(make_request(2'd1, 10'd1023, 10'd0, 1'b0));
      push_request(make_request(2'd1, 10'd512, 10'd512, 1'b1));
      push_request(make_request(2'd2, 10'd0, 10'd0, 1'b1));
      push_request(make_request(2'd2, 10'd1, 10'd1023, 1'b0));
      push_request(make_request(2'd3, 10'd0, 10'd1023, 1'b1));
      push_request(make_request(2'd3, 10'd2, 10'd300, 1'b0));
      wait_drained();

      // Random phases, each with fresh calibration points. Some phases run
      // one side or both without idle cycles so the pipeline fills.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         for (int channel = 0; channel < CHANNEL_COUNT; channel++) randomize_channel(channel);
         csr_write  <= 1'b0;
         send_quiet  = (phase == 1) || (phase == 4);
         recv_quiet  = (phase == 2) || (phase == 4);
         for (int item = 0; item < PHASE_ITEMS; item++) begin
            // Once in the middle of a phase the sender holds off until the
            // block has returned everything it owes.
            if (phase == 3 && item == PHASE_ITEMS / 2) wait_drained();
            pair = PAIR_W'($urandom_range(0, 3));
            push_request(make_request(pair, pick_raw(2 * pair), pick_raw(2 * pair + 1),
                                      1'($urandom_range(0, 1))));
         end
         wait_drained();
      end

      // Stray frames after the last expected one would show up here.
      repeat (LATENCY + 8) @(negedge clock);
      if (book.mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
